// ===== sv/lrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_pkg: shared definitions of the register reply parser
// Frame layout offsets, ethertype and status codes, and the result word type
// passed from the parser to the result queue.
// ----------------------------------------------------------------------------
package lrp_pkg;

	// Frame bytes at this position and beyond are neither parsed nor counted.
	localparam int MAX_FRAME_BYTES = 2048;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int TRAIL_W         = 11;
	localparam int CMP_W           = (POS_W > TRAIL_W) ? POS_W : TRAIL_W + 1;

	// Byte offsets inside the frame.
	localparam logic [POS_W-1:0] POS_ETYPE_LO  = POS_W'(12);
	localparam logic [POS_W-1:0] POS_ETYPE_HI  = POS_W'(13);
	localparam logic [POS_W-1:0] POS_SUBSYSTEM = POS_W'(14);
	localparam logic [POS_W-1:0] POS_OPERATION = POS_W'(15);
	localparam logic [POS_W-1:0] POS_DEVICE_LO = POS_W'(17);
	localparam logic [POS_W-1:0] POS_PACKET_LO = POS_W'(19);
	localparam logic [POS_W-1:0] POS_COUNT_LO  = POS_W'(21);
	localparam logic [POS_W-1:0] HEADER_BYTES  = POS_W'(22);
	localparam logic [POS_W-1:0] MIN_FRAME     = POS_W'(60);
	localparam logic [POS_W-1:0] ENTRY_BYTES   = POS_W'(6);
	localparam logic [CMP_W-1:0] TRAIL_MAX     = CMP_W'((1 << TRAIL_W) - 1);

	// Index of the final byte of a register entry.
	localparam logic [2:0] ENTRY_LAST_IDX = 3'd5;

	// Ethertypes.
	localparam logic [15:0] ETYPE_FAST  = 16'h0809;
	localparam logic [15:0] ETYPE_REG_A = 16'h0810;
	localparam logic [15:0] ETYPE_REG_B = 16'h0811;

	// Frame status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FAST       = 3'd1;
	localparam logic [2:0] ST_BADTYPE    = 3'd2;
	localparam logic [2:0] ST_BADFORMAT  = 3'd3;
	localparam logic [2:0] ST_INCOMPLETE = 3'd4;
	localparam logic [2:0] ST_SHORT      = 3'd5;

	// Result kinds.
	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SUBSYSTEM  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_READ_REPLY = 1'd1;

	// Result queue depth.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic               result_kind;
		logic [15:0]        entry_address;
		logic [31:0]        entry_value;
		logic [15:0]        ether_kind;
		logic [7:0]         subsystem_byte;
		logic [7:0]         operation_byte;
		logic [15:0]        device_id;
		logic [15:0]        packet_id;
		logic [15:0]        entry_count;
		logic [2:0]         status;
		logic [TRAIL_W-1:0] trailing_bytes;
		logic               last_in_run;
	} result_t;

	// Which of the two result slots the parser fills for the current byte.
	typedef struct packed {
		logic first_valid;
		logic second_valid;
	} push_t;

endpackage
`default_nettype wire

// ===== sv/lrp_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_frame_parser: per-byte frame parser
// Holds the frame state and turns each accepted byte into at most two result
// words: a completed register entry and, on the last byte, the frame summary.
// ----------------------------------------------------------------------------
module lrp_frame_parser (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [7:0]              frame_byte,
	input  wire logic                    frame_end,
	input  wire logic [7:0]              subsystem_code,
	input  wire logic [7:0]              read_reply_code,
	output      lrp_pkg::push_t          push,
	output      lrp_pkg::result_t        res_first,
	output      lrp_pkg::result_t        res_second
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_ENTRIES = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	logic [lrp_pkg::POS_W-1:0] pos_q, pos_d;
	logic [15:0] hs_q, hs_d;
	logic [15:0] etype_q, etype_d;
	logic [7:0]  subsys_q, subsys_d;
	logic [7:0]  oper_q, oper_d;
	logic [15:0] dev_q, dev_d;
	logic [15:0] pkt_q, pkt_d;
	logic [15:0] count_q, count_d;
	logic [15:0] left_q, left_d;
	logic [47:0] es_q, es_d;
	logic [2:0]  idx_q, idx_d;
	logic [lrp_pkg::POS_W-1:0] pend_q, pend_d;
	logic [2:0]  fst_q, fst_d;
	logic [1:0]  phase_q, phase_d;

	logic [47:0] es_next;
	logic        entry_fire;
	logic [2:0]  sum_status;
	logic [lrp_pkg::POS_W-1:0] base;
	logic [lrp_pkg::POS_W-1:0] diff;
	logic [lrp_pkg::TRAIL_W-1:0] trail;
	lrp_pkg::result_t entry_res;
	lrp_pkg::result_t sum_res;

	always_comb begin
		pos_d      = pos_q;
		hs_d       = hs_q;
		etype_d    = etype_q;
		subsys_d   = subsys_q;
		oper_d     = oper_q;
		dev_d      = dev_q;
		pkt_d      = pkt_q;
		count_d    = count_q;
		left_d     = left_q;
		es_d       = es_q;
		idx_d      = idx_q;
		pend_d     = pend_q;
		fst_d      = fst_q;
		phase_d    = phase_q;
		entry_fire = 1'b0;
		es_next    = {es_q[39:0], frame_byte};

		if (accept && (pos_q < lrp_pkg::POS_W'(lrp_pkg::MAX_FRAME_BYTES))) begin
			pos_d = pos_q + lrp_pkg::POS_W'(1);
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q >= lrp_pkg::POS_ETYPE_LO) begin
						hs_d = {hs_q[7:0], frame_byte};
					end
					if (pos_q == lrp_pkg::POS_ETYPE_HI) begin
						etype_d = hs_d;
						if (hs_d == lrp_pkg::ETYPE_FAST) begin
							fst_d   = lrp_pkg::ST_FAST;
							phase_d = PH_DONE;
						end else if (hs_d != lrp_pkg::ETYPE_REG_A &&
								hs_d != lrp_pkg::ETYPE_REG_B) begin
							fst_d   = lrp_pkg::ST_BADTYPE;
							phase_d = PH_DONE;
						end
					end else if (pos_q == lrp_pkg::POS_SUBSYSTEM) begin
						subsys_d = frame_byte;
					end else if (pos_q == lrp_pkg::POS_OPERATION) begin
						oper_d = frame_byte;
					end else if (pos_q == lrp_pkg::POS_DEVICE_LO) begin
						dev_d = hs_d;
					end else if (pos_q == lrp_pkg::POS_PACKET_LO) begin
						pkt_d = hs_d;
					end else if (pos_q == lrp_pkg::POS_COUNT_LO) begin
						count_d = hs_d;
						pend_d  = lrp_pkg::HEADER_BYTES;
						if (hs_d == 16'd0) begin
							fst_d   = lrp_pkg::ST_OK;
							phase_d = PH_DONE;
						end else if (subsys_q == subsystem_code &&
								oper_q == read_reply_code) begin
							left_d  = hs_d;
							phase_d = PH_ENTRIES;
						end else begin
							fst_d   = lrp_pkg::ST_BADFORMAT;
							phase_d = PH_DONE;
						end
					end
				end
				PH_ENTRIES: begin
					if (idx_q == lrp_pkg::ENTRY_LAST_IDX) begin
						entry_fire = 1'b1;
						es_d       = '0;
						idx_d      = '0;
						left_d     = left_q - 16'd1;
						pend_d     = pend_q + lrp_pkg::ENTRY_BYTES;
						if (left_q == 16'd1) begin
							fst_d   = lrp_pkg::ST_OK;
							phase_d = PH_DONE;
						end
					end else begin
						es_d  = es_next;
						idx_d = idx_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end

		// Frame summary, taken from the state after this byte.
		if (pos_d < lrp_pkg::HEADER_BYTES) begin
			sum_status = lrp_pkg::ST_SHORT;
		end else if (phase_d == PH_DONE) begin
			sum_status = fst_d;
		end else begin
			sum_status = lrp_pkg::ST_INCOMPLETE;
		end
		if (count_d != 16'd0 && pend_d < lrp_pkg::MIN_FRAME) begin
			base = lrp_pkg::MIN_FRAME;
		end else begin
			base = pend_d;
		end
		diff = (pos_d > base) ? (pos_d - base) : '0;
		if (sum_status != lrp_pkg::ST_OK) begin
			trail = '0;
		end else if (lrp_pkg::CMP_W'(diff) > lrp_pkg::TRAIL_MAX) begin
			trail = lrp_pkg::TRAIL_MAX[lrp_pkg::TRAIL_W-1:0];
		end else begin
			trail = diff[lrp_pkg::TRAIL_W-1:0];
		end

		entry_res.result_kind    = lrp_pkg::KIND_ENTRY;
		entry_res.entry_address  = es_next[47:32];
		entry_res.entry_value    = es_next[31:0];
		entry_res.ether_kind     = etype_d;
		entry_res.subsystem_byte = subsys_d;
		entry_res.operation_byte = oper_d;
		entry_res.device_id      = dev_d;
		entry_res.packet_id      = pkt_d;
		entry_res.entry_count    = count_d;
		entry_res.status         = lrp_pkg::ST_OK;
		entry_res.trailing_bytes = '0;
		entry_res.last_in_run    = ~frame_end;

		sum_res.result_kind    = lrp_pkg::KIND_SUMMARY;
		sum_res.entry_address  = '0;
		sum_res.entry_value    = '0;
		sum_res.ether_kind     = etype_d;
		sum_res.subsystem_byte = subsys_d;
		sum_res.operation_byte = oper_d;
		sum_res.device_id      = dev_d;
		sum_res.packet_id      = pkt_d;
		sum_res.entry_count    = count_d;
		sum_res.status         = sum_status;
		sum_res.trailing_bytes = trail;
		sum_res.last_in_run    = 1'b1;

		// The last byte closes the frame and returns all frame state to reset.
		if (accept && frame_end) begin
			pos_d    = '0;
			hs_d     = '0;
			etype_d  = '0;
			subsys_d = '0;
			oper_d   = '0;
			dev_d    = '0;
			pkt_d    = '0;
			count_d  = '0;
			left_d   = '0;
			es_d     = '0;
			idx_d    = '0;
			pend_d   = '0;
			fst_d    = lrp_pkg::ST_OK;
			phase_d  = PH_HEADER;
		end
	end

	always_comb begin
		push.first_valid  = accept && (entry_fire || frame_end);
		push.second_valid = accept && entry_fire && frame_end;
		res_first         = entry_fire ? entry_res : sum_res;
		res_second        = sum_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hs_q     <= '0;
			etype_q  <= '0;
			subsys_q <= '0;
			oper_q   <= '0;
			dev_q    <= '0;
			pkt_q    <= '0;
			count_q  <= '0;
			left_q   <= '0;
			es_q     <= '0;
			idx_q    <= '0;
			pend_q   <= '0;
			fst_q    <= lrp_pkg::ST_OK;
			phase_q  <= PH_HEADER;
		end else begin
			pos_q    <= pos_d;
			hs_q     <= hs_d;
			etype_q  <= etype_d;
			subsys_q <= subsys_d;
			oper_q   <= oper_d;
			dev_q    <= dev_d;
			pkt_q    <= pkt_d;
			count_q  <= count_d;
			left_q   <= left_d;
			es_q     <= es_d;
			idx_q    <= idx_d;
			pend_q   <= pend_d;
			fst_q    <= fst_d;
			phase_q  <= phase_d;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= lrp_pkg::ENTRY_LAST_IDX)
		else $error("entry byte index past the last entry byte");

	a_entries_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ENTRIES) |-> (left_q != 16'd0))
		else $error("entry phase with no entries left");

	a_entry_needs_entry_phase: assert property (@(posedge clk) disable iff (!arst_n)
		entry_fire |-> (phase_q == PH_ENTRIES && pend_q >= lrp_pkg::HEADER_BYTES))
		else $error("entry emitted outside the entry phase");

	a_frame_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_end) |=> (pos_q == '0 && phase_q == PH_HEADER))
		else $error("frame state not cleared after the last byte");

endmodule
`default_nettype wire

// ===== sv/lrp_result_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_result_fifo: result word queue
// Takes up to two result words per cycle and hands them out one per handshake.
// ----------------------------------------------------------------------------
module lrp_result_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lrp_pkg::push_t   push,
	input  wire lrp_pkg::result_t res_first,
	input  wire lrp_pkg::result_t res_second,
	output      logic             nearly_full,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      lrp_pkg::result_t res_out
);

	lrp_pkg::result_t mem_q [lrp_pkg::QUEUE_DEPTH];
	logic [lrp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lrp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lrp_pkg::QCNT_W-1:0] count_q;
	logic                       pop;
	logic [lrp_pkg::QPTR_W-1:0] wr_ptr_next;

	assign out_valid   = (count_q != '0);
	assign pop         = out_valid && !out_stall;
	assign res_out     = mem_q[rd_ptr_q];
	assign nearly_full = (count_q > lrp_pkg::QCNT_W'(lrp_pkg::QUEUE_DEPTH - 2));
	assign wr_ptr_next = wr_ptr_q + lrp_pkg::QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			mem_q[wr_ptr_q] <= res_first;
		end
		if (push.second_valid) begin
			mem_q[wr_ptr_next] <= res_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lrp_pkg::QPTR_W'(push.first_valid)
				+ lrp_pkg::QPTR_W'(push.second_valid);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lrp_pkg::QPTR_W'(1);
			end
			count_q <= count_q + lrp_pkg::QCNT_W'(push.first_valid)
				+ lrp_pkg::QCNT_W'(push.second_valid) - lrp_pkg::QCNT_W'(pop);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lrp_pkg::QCNT_W'(lrp_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.second_valid |-> push.first_valid)
		else $error("second slot pushed without the first");

	a_room_for_two: assert property (@(posedge clk) disable iff (!arst_n)
		push.first_valid |-> (count_q <= lrp_pkg::QCNT_W'(lrp_pkg::QUEUE_DEPTH - 2)))
		else $error("push into a queue without room for two words");

endmodule
`default_nettype wire

// ===== sv/lda_register_reply_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lda_register_reply_parser_top: register read reply parser
// Parses received frames byte by byte and reports register entries and a
// summary word for each frame.
// ----------------------------------------------------------------------------
// The block takes one raw frame byte per word, with frame_end marking the last
// byte, and accepts a new byte in every cycle that in_stall is low. Each byte
// is parsed in the cycle it is accepted and its results are written into a
// four-word result queue whose head word drives the output. A byte that
// completes a six-byte register entry gives an entry word; the last byte of a
// frame gives a summary word with the status and the trailing byte count, and
// when it also completes an entry the entry word comes first, with last_in_run
// low. The input stalls only while the queue has fewer than two free words,
// which happens only after the output side has been stalled; with the output
// always taken the queue never holds more than two words and the sustained rate
// is one byte per cycle. The two configuration registers, subsystem code
// (index 0) and read reply code (index 1), reset to zero; they must be written
// only while no frame is in flight; the block does not enforce it. Entries of
// a frame whose summary status is not ok are to be discarded downstream.
// ----------------------------------------------------------------------------
module lda_register_reply_parser_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lrp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]                      cfg_data,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic [7:0]                      frame_byte,
	input  wire logic                            frame_end,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            result_kind,
	output      logic [15:0]                     entry_address,
	output      logic [31:0]                     entry_value,
	output      logic [15:0]                     ether_kind,
	output      logic [7:0]                      subsystem_byte,
	output      logic [7:0]                      operation_byte,
	output      logic [15:0]                     device_id,
	output      logic [15:0]                     packet_id,
	output      logic [15:0]                     entry_count,
	output      logic [2:0]                      status,
	output      logic [lrp_pkg::TRAIL_W-1:0]     trailing_bytes,
	output      logic                            last_in_run
);

	// Configuration registers.
	logic [7:0] subsystem_code_q;
	logic [7:0] read_reply_code_q;

	logic             accept;
	logic             nearly_full;
	lrp_pkg::push_t   push;
	lrp_pkg::result_t res_first;
	lrp_pkg::result_t res_second;
	lrp_pkg::result_t res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subsystem_code_q  <= '0;
			read_reply_code_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrp_pkg::CFG_IDX_SUBSYSTEM:  subsystem_code_q  <= cfg_data;
				lrp_pkg::CFG_IDX_READ_REPLY: read_reply_code_q <= cfg_data;
			endcase
		end
	end

	// A byte is taken whenever the queue can hold both words it may cause.
	assign in_stall = nearly_full;
	assign accept   = in_valid && !nearly_full;

	lrp_frame_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.frame_byte      (frame_byte),
		.frame_end       (frame_end),
		.subsystem_code  (subsystem_code_q),
		.read_reply_code (read_reply_code_q),
		.push            (push),
		.res_first       (res_first),
		.res_second      (res_second)
	);

	lrp_result_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.res_first   (res_first),
		.res_second  (res_second),
		.nearly_full (nearly_full),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.res_out     (res_out)
	);

	// Unpack the head word of the queue onto the output fields.
	assign result_kind    = res_out.result_kind;
	assign entry_address  = res_out.entry_address;
	assign entry_value    = res_out.entry_value;
	assign ether_kind     = res_out.ether_kind;
	assign subsystem_byte = res_out.subsystem_byte;
	assign operation_byte = res_out.operation_byte;
	assign device_id      = res_out.device_id;
	assign packet_id      = res_out.packet_id;
	assign entry_count    = res_out.entry_count;
	assign status         = res_out.status;
	assign trailing_bytes = res_out.trailing_bytes;
	assign last_in_run    = res_out.last_in_run;

endmodule
`default_nettype wire
